### hw/rtl/mlnp_pkg.sv
package mlnp_pkg;

  // Default number of held-note entries.
  localparam int DefStackDepth = 128;

  localparam int KEY_W   = 7;
  localparam int VEL_W   = 7;
  localparam int ENTRY_W = KEY_W + VEL_W;
  localparam int STEP_W  = 5;

  // Play modes held in the configuration register.
  typedef enum logic [1:0] {
    MODE_MONO           = 2'd0,
    MODE_RETRIG_STORED  = 2'd1,
    MODE_RETRIG_RELEASE = 2'd2,
    MODE_POLY           = 2'd3
  } mode_t;

  // Event kinds on the input tuser bit.
  localparam logic CMD_ON  = 1'b0;
  localparam logic CMD_OFF = 1'b1;

  // Datapath operations, one per microcode step.
  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_ACCEPT,
    UOP_MATCH_INIT,
    UOP_DROP_INIT,
    UOP_WALK,
    UOP_SET_COUNT,
    UOP_PUSH,
    UOP_EMIT_END,
    UOP_EMIT_ON,
    UOP_EMIT_OFF_FINAL,
    UOP_EMIT_OFF_READ,
    UOP_EMIT_RETRIG,
    UOP_EMIT_POLY
  } uop_t;

  // Jump conditions.
  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_ITEM,
    COND_POLY,
    COND_IS_OFF,
    COND_NOT_SOUNDING,
    COND_WALK_BUSY,
    COND_NOT_FULL,
    COND_NOT_SOUNDING_KEY,
    COND_RETRIG
  } cond_t;

  typedef struct packed {
    uop_t              op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ucw_t;

  // Program step addresses.
  localparam logic [STEP_W-1:0] ST_IDLE       = 5'd0;
  localparam logic [STEP_W-1:0] ST_DISPATCH   = 5'd1;
  localparam logic [STEP_W-1:0] ST_ON_CHECK   = 5'd2;
  localparam logic [STEP_W-1:0] ST_ON_SOUND   = 5'd3;
  localparam logic [STEP_W-1:0] ST_ON_END     = 5'd4;
  localparam logic [STEP_W-1:0] ST_ON_MINIT   = 5'd5;
  localparam logic [STEP_W-1:0] ST_ON_MWALK   = 5'd6;
  localparam logic [STEP_W-1:0] ST_ON_MCOUNT  = 5'd7;
  localparam logic [STEP_W-1:0] ST_ON_FULL    = 5'd8;
  localparam logic [STEP_W-1:0] ST_ON_DINIT   = 5'd9;
  localparam logic [STEP_W-1:0] ST_ON_DWALK   = 5'd10;
  localparam logic [STEP_W-1:0] ST_ON_DCOUNT  = 5'd11;
  localparam logic [STEP_W-1:0] ST_ON_PUSH    = 5'd12;
  localparam logic [STEP_W-1:0] ST_ON_EMIT    = 5'd13;
  localparam logic [STEP_W-1:0] ST_OFF_MINIT  = 5'd14;
  localparam logic [STEP_W-1:0] ST_OFF_MWALK  = 5'd15;
  localparam logic [STEP_W-1:0] ST_OFF_MCOUNT = 5'd16;
  localparam logic [STEP_W-1:0] ST_OFF_CHECK  = 5'd17;
  localparam logic [STEP_W-1:0] ST_OFF_RETRIG = 5'd18;
  localparam logic [STEP_W-1:0] ST_OFF_FINAL  = 5'd19;
  localparam logic [STEP_W-1:0] ST_OFF_READ   = 5'd20;
  localparam logic [STEP_W-1:0] ST_OFF_AGAIN  = 5'd21;
  localparam logic [STEP_W-1:0] ST_POLY       = 5'd22;

  // Control from the sequencer to the note stack.
  typedef struct packed {
    logic walk_init;
    logic drop_first;
    logic walk_step;
    logic set_count;
    logic push;
    logic read_top;
    logic clear;
  } stk_ctrl_t;

  // Status from the note stack.
  typedef struct packed {
    logic             busy;
    logic             full;
    logic             nonempty;
    logic [KEY_W-1:0] top_key;
    logic [VEL_W-1:0] top_vel;
  } stk_stat_t;

  // Microcode ROM: operation, jump condition and jump target per step.
  function automatic ucw_t ucode(input logic [STEP_W-1:0] step);
    ucw_t w;
    w = '{op: UOP_NOP, cond: COND_ALWAYS, target: ST_IDLE};
    unique case (step)
      ST_IDLE:       w = '{op: UOP_ACCEPT,         cond: COND_NO_ITEM,
                           target: ST_IDLE};
      ST_DISPATCH:   w = '{op: UOP_NOP,            cond: COND_POLY,
                           target: ST_POLY};
      ST_ON_CHECK:   w = '{op: UOP_NOP,            cond: COND_IS_OFF,
                           target: ST_OFF_MINIT};
      ST_ON_SOUND:   w = '{op: UOP_NOP,            cond: COND_NOT_SOUNDING,
                           target: ST_ON_MINIT};
      ST_ON_END:     w = '{op: UOP_EMIT_END,       cond: COND_NEVER,
                           target: ST_IDLE};
      ST_ON_MINIT:   w = '{op: UOP_MATCH_INIT,     cond: COND_NEVER,
                           target: ST_IDLE};
      ST_ON_MWALK:   w = '{op: UOP_WALK,           cond: COND_WALK_BUSY,
                           target: ST_ON_MWALK};
      ST_ON_MCOUNT:  w = '{op: UOP_SET_COUNT,      cond: COND_NEVER,
                           target: ST_IDLE};
      ST_ON_FULL:    w = '{op: UOP_NOP,            cond: COND_NOT_FULL,
                           target: ST_ON_PUSH};
      ST_ON_DINIT:   w = '{op: UOP_DROP_INIT,      cond: COND_NEVER,
                           target: ST_IDLE};
      ST_ON_DWALK:   w = '{op: UOP_WALK,           cond: COND_WALK_BUSY,
                           target: ST_ON_DWALK};
      ST_ON_DCOUNT:  w = '{op: UOP_SET_COUNT,      cond: COND_NEVER,
                           target: ST_IDLE};
      ST_ON_PUSH:    w = '{op: UOP_PUSH,           cond: COND_NEVER,
                           target: ST_IDLE};
      ST_ON_EMIT:    w = '{op: UOP_EMIT_ON,        cond: COND_ALWAYS,
                           target: ST_IDLE};
      ST_OFF_MINIT:  w = '{op: UOP_MATCH_INIT,     cond: COND_NEVER,
                           target: ST_IDLE};
      ST_OFF_MWALK:  w = '{op: UOP_WALK,           cond: COND_WALK_BUSY,
                           target: ST_OFF_MWALK};
      ST_OFF_MCOUNT: w = '{op: UOP_SET_COUNT,      cond: COND_NEVER,
                           target: ST_IDLE};
      ST_OFF_CHECK:  w = '{op: UOP_NOP,            cond: COND_NOT_SOUNDING_KEY,
                           target: ST_IDLE};
      ST_OFF_RETRIG: w = '{op: UOP_NOP,            cond: COND_RETRIG,
                           target: ST_OFF_READ};
      ST_OFF_FINAL:  w = '{op: UOP_EMIT_OFF_FINAL, cond: COND_ALWAYS,
                           target: ST_IDLE};
      ST_OFF_READ:   w = '{op: UOP_EMIT_OFF_READ,  cond: COND_NEVER,
                           target: ST_IDLE};
      ST_OFF_AGAIN:  w = '{op: UOP_EMIT_RETRIG,    cond: COND_ALWAYS,
                           target: ST_IDLE};
      ST_POLY:       w = '{op: UOP_EMIT_POLY,      cond: COND_ALWAYS,
                           target: ST_IDLE};
      default:       w = '{op: UOP_NOP,            cond: COND_ALWAYS,
                           target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

### hw/rtl/mono_last_note_priority_core.sv
// Poly mode: the item is dispatched straight to its note-on or note-off result.
// Mono note-off: a match walk drops the key from the note memory; when it was the sounding
// note, a note-off follows and, in the retrigger modes with notes still held, a note-on of
// the newest held note. Mono note-on: a note-off for any sounding note, a match walk, a drop
// walk of the oldest entry when the stack is full, then the push and the note-on.
// One item is in work at a time and stalls hold the sequencer. Reset (rst) selects
// poly mode, empties the stack and leaves nothing sounding.
module mono_last_note_priority_core
  import mlnp_pkg::*;
#(
  parameter int STACK_DEPTH = DefStackDepth
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration: play_mode.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  // Input items.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [6:0] note, [13:7] velocity, [15:14] zero
  input  logic        s_tuser,   // [0] cmd
  // Result items.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [6:0] out_note, [13:7] out_velocity, [15:14] zero
  output logic        m_tuser,   // [0] is_on
  output logic        m_tlast
);

  mode_t             mode;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  ucw_t              ucw;

  logic              in_cmd;
  logic [KEY_W-1:0]  in_key;
  logic [VEL_W-1:0]  in_vel;

  logic              sounding_valid;
  logic [KEY_W-1:0]  sounding_note;

  logic              out_valid;
  logic              out_is_on;
  logic [KEY_W-1:0]  out_note;
  logic [VEL_W-1:0]  out_vel;
  logic              out_last;

  logic              is_emit;
  logic              e_on;
  logic [KEY_W-1:0]  e_note;
  logic [VEL_W-1:0]  e_vel;
  logic              e_last;
  logic              hold;
  logic              cond_true;

  stk_ctrl_t         st_ctrl;
  stk_stat_t         st_stat;

  assign ucw = ucode(step);

  // Result fields for the emitting operations.
  always_comb begin
    is_emit = 1'b1;
    e_on    = 1'b0;
    e_note  = in_key;
    e_vel   = in_vel;
    e_last  = 1'b1;
    unique case (ucw.op)
      UOP_EMIT_END: begin
        e_note = sounding_note;
        e_vel  = '0;
        e_last = 1'b0;
      end
      UOP_EMIT_ON: begin
        e_on = 1'b1;
      end
      UOP_EMIT_OFF_FINAL: begin
        e_on = 1'b0;
      end
      UOP_EMIT_OFF_READ: begin
        e_last = 1'b0;
      end
      UOP_EMIT_RETRIG: begin
        e_on   = 1'b1;
        e_note = st_stat.top_key;
        e_vel  = (mode == MODE_RETRIG_RELEASE) ? in_vel : st_stat.top_vel;
      end
      UOP_EMIT_POLY: begin
        e_on = (in_cmd == CMD_ON);
      end
      default: begin
        is_emit = 1'b0;
      end
    endcase
  end

  // An emitting step waits while the output register is full and stalled.
  assign hold = is_emit && out_valid && !m_tready;

  // Jump condition decode.
  always_comb begin
    unique case (ucw.cond)
      COND_NEVER:            cond_true = 1'b0;
      COND_ALWAYS:           cond_true = 1'b1;
      COND_NO_ITEM:          cond_true = !s_tvalid;
      COND_POLY:             cond_true = (mode == MODE_POLY);
      COND_IS_OFF:           cond_true = (in_cmd == CMD_OFF);
      COND_NOT_SOUNDING:     cond_true = !sounding_valid;
      COND_WALK_BUSY:        cond_true = st_stat.busy;
      COND_NOT_FULL:         cond_true = !st_stat.full;
      COND_NOT_SOUNDING_KEY: cond_true = !sounding_valid || (sounding_note != in_key);
      COND_RETRIG:           cond_true = st_stat.nonempty &&
                                         ((mode == MODE_RETRIG_STORED) ||
                                          (mode == MODE_RETRIG_RELEASE));
      default:               cond_true = 1'b1;
    endcase
  end

  // Step counter: hold, jump or fall through.
  always_comb begin
    if (hold) begin
      step_next = step;
    end else if (cond_true) begin
      step_next = ucw.target;
    end else begin
      step_next = step + 1'b1;
    end
  end

  assign s_tready = (ucw.op == UOP_ACCEPT) && !rst;

  // Stack control from the current control word.
  always_comb begin
    st_ctrl.walk_init  = (ucw.op == UOP_MATCH_INIT) || (ucw.op == UOP_DROP_INIT);
    st_ctrl.drop_first = (ucw.op == UOP_DROP_INIT);
    st_ctrl.walk_step  = (ucw.op == UOP_WALK);
    st_ctrl.set_count  = (ucw.op == UOP_SET_COUNT);
    st_ctrl.push       = (ucw.op == UOP_PUSH);
    st_ctrl.read_top   = (ucw.op == UOP_EMIT_OFF_READ);
    st_ctrl.clear      = cfg_we && (mode_t'(cfg_wdata) == MODE_POLY);
  end

  mlnp_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .rst  (rst),
    .ctrl (st_ctrl),
    .key  (in_key),
    .vel  (in_vel),
    .stat (st_stat)
  );

  // Sequencer, mode register and sounding note.
  always_ff @(posedge clk) begin
    if (rst) begin
      step           <= ST_IDLE;
      mode           <= MODE_POLY;
      sounding_valid <= 1'b0;
      sounding_note  <= '0;
    end else begin
      step <= step_next;
      if (cfg_we) begin
        mode <= mode_t'(cfg_wdata);
        if (mode_t'(cfg_wdata) == MODE_POLY) begin
          sounding_valid <= 1'b0;
          sounding_note  <= '0;
        end
      end else if (ucw.op == UOP_PUSH) begin
        sounding_valid <= 1'b1;
        sounding_note  <= in_key;
      end else if ((ucw.op == UOP_EMIT_OFF_FINAL) && !hold) begin
        sounding_valid <= 1'b0;
        sounding_note  <= '0;
      end else if ((ucw.op == UOP_EMIT_RETRIG) && !hold) begin
        sounding_note <= st_stat.top_key;
      end
    end
  end

  // Input item register.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd <= s_tuser;
      in_key <= s_tdata[KEY_W-1:0];
      in_vel <= s_tdata[KEY_W+VEL_W-1:KEY_W];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (is_emit && !hold) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_emit && !hold) begin
      out_is_on <= e_on;
      out_note  <= e_note;
      out_vel   <= e_vel;
      out_last  <= e_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_vel, out_note};
  assign m_tuser  = out_is_on;
  assign m_tlast  = out_last;

  // In poly mode the stack is empty and nothing sounds.
  a_poly_clean: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_POLY) |-> (!sounding_valid && !st_stat.nonempty))
    else $error("poly mode with held or sounding notes");

  // A push leaves a note sounding unless a configuration write comes in the same cycle.
  a_push_sounds: assert property (@(posedge clk) disable iff (rst)
    (ucw.op == UOP_PUSH) && !cfg_we |=> sounding_valid)
    else $error("note-on left nothing sounding");

  // A retrigger only happens with notes still held.
  a_retrig_held: assert property (@(posedge clk) disable iff (rst)
    (ucw.op == UOP_EMIT_RETRIG) |-> st_stat.nonempty)
    else $error("retrigger from an empty stack");

endmodule

### hw/rtl/mlnp_stack.sv
module mlnp_stack
  import mlnp_pkg::*;
#(
  parameter int STACK_DEPTH = DefStackDepth
) (
  input  logic             clk,
  input  logic             rst,
  input  stk_ctrl_t        ctrl,
  input  logic [KEY_W-1:0] key,
  input  logic [VEL_W-1:0] vel,
  output stk_stat_t        stat
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  logic [ENTRY_W-1:0] mem [STACK_DEPTH];

  logic [CW-1:0]      count;
  logic [CW-1:0]      rd_idx;
  logic [CW-1:0]      wr_idx;
  logic [ENTRY_W-1:0] rd_data;
  logic               pipe_valid;
  logic               pipe_first;
  logic               match_en;
  logic               drop_en;

  logic               rd_issue;
  logic               keep;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [CW-1:0]      count_m1;

  // The walk reads entry rd_idx while the entry read in the previous cycle is
  // written back at wr_idx, unless it holds the key or is the dropped oldest.
  assign rd_issue = ctrl.walk_step && (rd_idx < count);
  assign keep = pipe_valid && !(drop_en && pipe_first) &&
                !(match_en && (rd_data[ENTRY_W-1:VEL_W] == key));
  assign count_m1 = count - 1'b1;

  // Single write port shared by the walk and the push.
  always_comb begin
    mem_we    = (ctrl.walk_step && keep) || ctrl.push;
    mem_waddr = ctrl.push ? count[AW-1:0] : wr_idx[AW-1:0];
    mem_wdata = ctrl.push ? {key, vel} : rd_data;
  end

  // Memory array with a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_issue) begin
      rd_data <= mem[rd_idx[AW-1:0]];
    end else if (ctrl.read_top) begin
      rd_data <= mem[count_m1[AW-1:0]];
    end
  end

  // Walk pointers, pipeline flag and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      rd_idx     <= '0;
      wr_idx     <= '0;
      pipe_valid <= 1'b0;
      pipe_first <= 1'b0;
      match_en   <= 1'b0;
      drop_en    <= 1'b0;
    end else begin
      pipe_valid <= rd_issue;
      pipe_first <= (rd_idx == '0);
      if (ctrl.walk_init) begin
        rd_idx   <= '0;
        wr_idx   <= '0;
        match_en <= !ctrl.drop_first;
        drop_en  <= ctrl.drop_first;
      end else if (ctrl.walk_step) begin
        if (rd_issue) begin
          rd_idx <= rd_idx + 1'b1;
        end
        if (keep) begin
          wr_idx <= wr_idx + 1'b1;
        end
      end
      if (ctrl.clear) begin
        count <= '0;
      end else if (ctrl.set_count) begin
        count <= wr_idx;
      end else if (ctrl.push) begin
        count <= count + 1'b1;
      end
    end
  end

  // Status back to the sequencer.
  always_comb begin
    stat.busy     = (rd_idx < count) || pipe_valid;
    stat.full     = (count == DEPTH_C);
    stat.nonempty = (count != '0);
    stat.top_key  = rd_data[ENTRY_W-1:VEL_W];
    stat.top_vel  = rd_data[VEL_W-1:0];
  end

  // The fill count never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("note stack count exceeds depth");

  // Compaction never writes ahead of the entry being read.
  a_walk_order: assert property (@(posedge clk) disable iff (rst)
    pipe_valid |-> (wr_idx < rd_idx))
    else $error("walk write index overtook read index");

  // A push always lands on a free entry.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    ctrl.push |-> (count < DEPTH_C))
    else $error("push into a full note stack");

endmodule

### dv/mono_last_note_priority_core_test.sv
module mono_last_note_priority_core_test;
  import mlnp_pkg::*;

  localparam int Depth = DefStackDepth;
  // Longest silent walk: a note-on with a full stack takes about two passes over it.
  localparam int SettleCycles = 2 * Depth + 60;

  // One emitted note event as the block should produce it.
  typedef struct {
    logic             is_on;
    logic [KEY_W-1:0] key;
    logic [VEL_W-1:0] vel;
    logic             last;
  } note_evt_t;

  // Tracks held keys and the sounding voice, and holds the note events still due.
  class voice_board;
    mode_t              mode;
    logic [ENTRY_W-1:0] held [Depth];
    int unsigned        held_n;
    bit                 sounding;
    logic [KEY_W-1:0]   snd_key;
    logic [VEL_W-1:0]   snd_vel;
    note_evt_t          due_events[$];
    int unsigned        faults;

    function new();
      mode = MODE_POLY;
      faults = 0;
      clear_voices();
    endfunction

    function void clear_voices();
      foreach (held[i]) held[i] = '0;
      held_n = 0;
      sounding = 1'b0;
      snd_key = '0;
      snd_vel = '0;
    endfunction

    function void set_mode(mode_t m);
      mode = m;
      if (m == MODE_POLY) clear_voices();
    endfunction

    function int unsigned pending();
      return due_events.size();
    endfunction

    function int unsigned held_count();
      return held_n;
    endfunction

    function logic [KEY_W-1:0] held_key_at(int unsigned i);
      return held[i][ENTRY_W-1:VEL_W];
    endfunction

    function note_evt_t mk(logic on, logic [KEY_W-1:0] key, logic [VEL_W-1:0] vel);
      note_evt_t e;
      e = '{is_on: on, key: key, vel: vel, last: 1'b0};
      return e;
    endfunction

    // Remove every entry of a key, keeping the order of the others.
    function void drop_key(logic [KEY_W-1:0] key);
      int unsigned j;
      j = 0;
      for (int unsigned i = 0; i < held_n; i++) begin
        if (held[i][ENTRY_W-1:VEL_W] != key) begin
          held[j] = held[i];
          j++;
        end
      end
      held_n = j;
    endfunction

    // Put a key on top; a full stack loses its oldest entry.
    function void push_key(logic [KEY_W-1:0] key, logic [VEL_W-1:0] vel);
      if (held_n >= Depth) begin
        for (int i = 0; i < Depth - 1; i++) held[i] = held[i+1];
        held_n = Depth - 1;
      end
      held[held_n] = {key, vel};
      held_n++;
    endfunction

    // Work out the note events caused by one accepted input item.
    function void take_event(logic cmd, logic [KEY_W-1:0] key, logic [VEL_W-1:0] vel);
      note_evt_t          outs[$];
      logic [ENTRY_W-1:0] top;
      if (mode == MODE_POLY) begin
        outs.insert(outs.size(), mk(cmd == CMD_ON, key, vel));
      end else if (cmd == CMD_ON) begin
        if (sounding) outs.insert(outs.size(), mk(1'b0, snd_key, '0));
        drop_key(key);
        push_key(key, vel);
        outs.insert(outs.size(), mk(1'b1, key, vel));
        sounding = 1'b1;
        snd_key = key;
        snd_vel = vel;
      end else begin
        drop_key(key);
        if (sounding && snd_key == key) begin
          outs.insert(outs.size(), mk(1'b0, key, vel));
          if (held_n > 0 && (mode == MODE_RETRIG_STORED || mode == MODE_RETRIG_RELEASE)) begin
            // The newest held key sounds again; its stored velocity stays on record.
            top = held[held_n-1];
            outs.insert(outs.size(), mk(1'b1, top[ENTRY_W-1:VEL_W],
                              (mode == MODE_RETRIG_RELEASE) ? vel : top[VEL_W-1:0]));
            snd_key = top[ENTRY_W-1:VEL_W];
            snd_vel = top[VEL_W-1:0];
          end else begin
            sounding = 1'b0;
            snd_key = '0;
            snd_vel = '0;
          end
        end
      end
      if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
      foreach (outs[i]) due_events.insert(due_events.size(), outs[i]);
    endfunction

    // Compare one emitted item with the oldest event still due.
    function void check_emitted(logic is_on, logic [KEY_W-1:0] key, logic [VEL_W-1:0] vel,
                                logic last);
      note_evt_t want;
      if (due_events.size() == 0) begin
        $error("unexpected item: is_on=%0d out_note=%0d out_velocity=%0d last=%0d",
               is_on, key, vel, last);
        faults++;
        return;
      end
      want = due_events.pop_front();
      if (is_on !== want.is_on) begin
        $error("is_on: expected %0d, got %0d", want.is_on, is_on);
        faults++;
      end
      if (key !== want.key) begin
        $error("out_note: expected %0d, got %0d", want.key, key);
        faults++;
      end
      if (vel !== want.vel) begin
        $error("out_velocity: expected %0d, got %0d", want.vel, vel);
        faults++;
      end
      if (last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, last);
        faults++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  voice_board board = new();
  bit         tx_calm;
  bit         rx_calm;
  int         rx_hold;

  mono_last_note_priority_core uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one; none while calm.
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Result side back-pressure.
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      m_tready = 1'b0;
      rx_hold--;
    end else begin
      m_tready = 1'b1;
      rx_hold = pick_gap(rx_calm);
    end
  end

  // Every accepted result item is checked at the edge that moves it.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      board.check_emitted(m_tuser, m_tdata[KEY_W-1:0], m_tdata[KEY_W+VEL_W-1:KEY_W], m_tlast);
  end

  // Offer one note event, wait for it to be taken, then maybe idle.
  task automatic send_event(logic cmd, logic [KEY_W-1:0] key, logic [VEL_W-1:0] vel);
    int n;
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata = {2'b00, vel, key};
    s_tuser = cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.take_event(cmd, key, vel);
    n = pick_gap(tx_calm);
    if (n > 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Stop sending until nothing is due, then let a silent walk finish.
  task automatic settle(int extra);
    @(negedge clk);
    s_tvalid = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_mode(mode_t m);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = m;
    @(negedge clk);
    cfg_we = 1'b0;
    board.set_mode(m);
  endtask

  // Random traffic: outside poly mode mostly presses and releases of held keys, some noise.
  task automatic run_phase(int n_items, bit deep);
    int               pool_size;
    int               pool_base;
    int unsigned      target;
    int unsigned      k;
    int               r;
    logic             cmd;
    logic [KEY_W-1:0] key;
    logic [VEL_W-1:0] vel;
    pool_size = deep ? 128 : $urandom_range(3, 12);
    pool_base = $urandom_range(0, 128 - pool_size);
    target = deep ? 128 : $urandom_range(1, pool_size);
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2) settle(0);
      r = $urandom_range(0, 99);
      vel = VEL_W'($urandom_range(0, 127));
      k = board.held_count();
      if (r < 12 || board.mode == MODE_POLY) begin
        cmd = 1'($urandom_range(0, 1));
        key = KEY_W'($urandom_range(0, 127));
      end else if (k == 0 || (k < target && r < (deep ? 90 : 65))) begin
        cmd = CMD_ON;
        key = KEY_W'(pool_base + $urandom_range(0, pool_size - 1));
      end else begin
        // Releasing the newest key often hits the sounding note.
        cmd = CMD_OFF;
        if (r < 40) key = board.held_key_at(k - 1);
        else key = board.held_key_at($urandom_range(0, k - 1));
      end
      send_event(cmd, key, vel);
    end
  endtask

  // Run limit.
  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    mode_t m;
    bit    deep;
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = MODE_POLY;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = CMD_ON;
    m_tready = 1'b0;
    rx_hold = 0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Poly mode after reset: field extremes pass straight through.
    send_event(CMD_ON, 7'd0, 7'd0);
    send_event(CMD_ON, 7'd127, 7'd127);
    send_event(CMD_OFF, 7'd127, 7'd127);
    send_event(CMD_OFF, 7'd0, 7'd0);

    // Mono without retrigger: restrike of the sounding key, releases with and without note-off.
    settle(SettleCycles);
    write_mode(MODE_MONO);
    send_event(CMD_ON, 7'd60, 7'd100);
    send_event(CMD_ON, 7'd64, 7'd90);
    send_event(CMD_ON, 7'd64, 7'd50);
    send_event(CMD_OFF, 7'd60, 7'd10);
    send_event(CMD_OFF, 7'd64, 7'd20);
    send_event(CMD_OFF, 7'd64, 7'd30);

    // Retrigger with the stored velocity, down to an empty stack.
    settle(SettleCycles);
    write_mode(MODE_RETRIG_STORED);
    send_event(CMD_ON, 7'd10, 7'd11);
    send_event(CMD_ON, 7'd20, 7'd22);
    send_event(CMD_ON, 7'd30, 7'd33);
    send_event(CMD_OFF, 7'd30, 7'd5);
    send_event(CMD_OFF, 7'd20, 7'd6);
    send_event(CMD_OFF, 7'd10, 7'd7);

    // Retrigger with the release velocity.
    settle(SettleCycles);
    write_mode(MODE_RETRIG_RELEASE);
    send_event(CMD_ON, 7'd1, 7'd1);
    send_event(CMD_ON, 7'd2, 7'd2);
    send_event(CMD_OFF, 7'd2, 7'd99);
    send_event(CMD_OFF, 7'd1, 7'd0);
    send_event(CMD_ON, 7'd127, 7'd127);
    send_event(CMD_ON, 7'd0, 7'd0);
    send_event(CMD_OFF, 7'd0, 7'd127);

    // Random phases; the first eight walk through every mode, poly clears held keys.
    for (int p = 0; p < 16; p++) begin
      m = (p < 8) ? mode_t'(p % 4) : mode_t'($urandom_range(0, 3));
      deep = (p == 5 || p == 6);
      settle(SettleCycles);
      write_mode(m);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      run_phase(deep ? 150 : 70, deep);
    end

    tx_calm = 1'b0;
    rx_calm = 1'b0;
    settle(SettleCycles);
    if (board.faults == 0 && board.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/mlnp_pkg.sv
hw/rtl/mlnp_stack.sv
hw/rtl/mono_last_note_priority_core.sv
dv/mono_last_note_priority_core_test.sv
